// ===== src/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared widths, register codes and reset values of the vertex rotate and
// project core.
// ----------------------------------------------------------------------------
package vrp_pkg;

	localparam int ANGLE_BITS_DEF = 12;
	localparam int TRIG_BITS_DEF  = 16;

	localparam int ANGLE_W    = 12;
	localparam int FOCAL_W    = 16;
	localparam int DIST_W     = 16;
	localparam int SCREEN_W   = 13;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam int VERT_W  = 16;
	localparam int COLOR_W = 8;
	localparam int COORD_W = 18;
	localparam int OUT_W   = 24;
	localparam int TDATA_W = 3 * VERT_W + 3 * COLOR_W;
	localparam int MDATA_W = 2 * OUT_W + 3 * COLOR_W;

	localparam int DEN_W    = COORD_W + 1;
	localparam int NUM_W    = FOCAL_W + 1 + COORD_W;
	localparam int MAG_W    = NUM_W - 1;
	localparam int DMAG_W   = DEN_W;
	localparam int DVD_W    = MAG_W + 1;
	localparam int DVS_W    = DMAG_W + 1;
	localparam int CENTRE_W = SCREEN_W + 7;
	localparam int FIN_W    = DVD_W + 2;

	localparam logic signed [FIN_W-1:0] SAT_HI = FIN_W'((longint'(1) <<< (OUT_W - 1)) - 1);
	localparam logic signed [FIN_W-1:0] SAT_LO = FIN_W'(-(longint'(1) <<< (OUT_W - 1)));

	localparam logic [ANGLE_W-1:0]  ANGLE_RST  = '0;
	localparam logic [FOCAL_W-1:0]  FOCAL_RST  = FOCAL_W'(256);
	localparam logic [DIST_W-1:0]   DIST_RST   = DIST_W'(1024);
	localparam logic [SCREEN_W-1:0] WIDTH_RST  = SCREEN_W'(640);
	localparam logic [SCREEN_W-1:0] HEIGHT_RST = SCREEN_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE_X   = 3'd0,
		CFG_ANGLE_Y   = 3'd1,
		CFG_ANGLE_Z   = 3'd2,
		CFG_FOCAL     = 3'd3,
		CFG_DISTANCE  = 3'd4,
		CFG_WIDTH     = 3'd5,
		CFG_HEIGHT    = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} color_t;

	typedef struct packed {
		color_t             color;
		logic [OUT_W-1:0]   sy;
		logic [OUT_W-1:0]   sx;
	} result_t;

endpackage

// ===== src/vrp_trig_rom.sv =====
// ----------------------------------------------------------------------------
// vrp_trig_rom
// Quarter-wave sine table with registered sine and cosine reads of one angle.
// ----------------------------------------------------------------------------
module vrp_trig_rom #(
	parameter int ANGLE_BITS = vrp_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_BITS  = vrp_pkg::TRIG_BITS_DEF
) (
	input  logic                        clk,
	input  logic [ANGLE_BITS-1:0]       angle,
	output logic signed [TRIG_BITS-1:0] sin_v,
	output logic signed [TRIG_BITS-1:0] cos_v
);

	localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
	localparam int ADDR_W    = ANGLE_BITS - 1;
	localparam int TRIG_FRAC = TRIG_BITS - 1;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [TRIG_FRAC-1:0] rom_t [QUARTER+1];

	function automatic longint unsigned taylor_div(longint unsigned t, int n);
		unique case (n)
			1:       return t / 6;
			2:       return t / 20;
			3:       return t / 42;
			4:       return t / 72;
			5:       return t / 110;
			6:       return t / 156;
			7:       return t / 210;
			8:       return t / 272;
			9:       return t / 342;
			10:      return t / 420;
			11:      return t / 506;
			default: return t / 600;
		endcase
	endfunction

	function automatic rom_t build_rom();
		rom_t            tbl;
		longint unsigned th;
		longint unsigned th2;
		longint unsigned term;
		longint          sum;
		longint          res;
		for (int r = 0; r <= QUARTER; r++) begin
			th   = (longint'(r) * HALF_PI_Q30 + longint'(QUARTER / 2)) >> (ANGLE_BITS - 2);
			th2  = (th * th) >> 30;
			sum  = longint'(th);
			term = th;
			for (int n = 1; n <= 12; n++) begin
				term = taylor_div((term * th2) >> 30, n);
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			res = (sum + (longint'(1) <<< (30 - TRIG_FRAC - 1))) >>> (30 - TRIG_FRAC);
			if (res > (longint'(1) <<< TRIG_FRAC) - 1) begin
				res = (longint'(1) <<< TRIG_FRAC) - 1;
			end
			tbl[r] = TRIG_FRAC'(res);
		end
		return tbl;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [ANGLE_BITS-1:0] cos_angle;
	logic [ADDR_W-1:0]     sin_addr;
	logic [ADDR_W-1:0]     cos_addr;
	logic [TRIG_FRAC-1:0]  sin_mag_q;
	logic [TRIG_FRAC-1:0]  cos_mag_q;
	logic                  sin_neg_q;
	logic                  cos_neg_q;

	assign cos_angle = angle + ANGLE_BITS'(QUARTER);

	assign sin_addr = angle[ANGLE_BITS-2]
		? ADDR_W'(QUARTER) - ADDR_W'(angle[ANGLE_BITS-3:0])
		: ADDR_W'(angle[ANGLE_BITS-3:0]);
	assign cos_addr = cos_angle[ANGLE_BITS-2]
		? ADDR_W'(QUARTER) - ADDR_W'(cos_angle[ANGLE_BITS-3:0])
		: ADDR_W'(cos_angle[ANGLE_BITS-3:0]);

	always_ff @(posedge clk) begin
		sin_mag_q <= ROM[sin_addr];
		cos_mag_q <= ROM[cos_addr];
		sin_neg_q <= angle[ANGLE_BITS-1];
		cos_neg_q <= cos_angle[ANGLE_BITS-1];
	end

	assign sin_v = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
	assign cos_v = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});

endmodule

// ===== src/vrp_rotator.sv =====
// ----------------------------------------------------------------------------
// vrp_rotator
// Two-stage plane rotation: u' = u*c - v*s, v' = u*s + v*c, rounded to Q10.8.
// ----------------------------------------------------------------------------
module vrp_rotator #(
	parameter int TRIG_BITS = vrp_pkg::TRIG_BITS_DEF,
	parameter int SIDE_W    = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic signed [vrp_pkg::COORD_W-1:0] in_u,
	input  logic signed [vrp_pkg::COORD_W-1:0] in_v,
	input  logic [SIDE_W-1:0]                  in_side,
	input  logic signed [TRIG_BITS-1:0]        sin_v,
	input  logic signed [TRIG_BITS-1:0]        cos_v,
	output logic                               out_valid,
	output logic signed [vrp_pkg::COORD_W-1:0] out_u,
	output logic signed [vrp_pkg::COORD_W-1:0] out_v,
	output logic [SIDE_W-1:0]                  out_side
);

	localparam int TRIG_FRAC = TRIG_BITS - 1;
	localparam int PROD_W    = vrp_pkg::COORD_W + TRIG_BITS;
	localparam int SUM_W     = PROD_W + 1;
	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(longint'(1) <<< (TRIG_FRAC - 1));

	logic                     valid_s1;
	logic signed [PROD_W-1:0] uc_s1;
	logic signed [PROD_W-1:0] vs_s1;
	logic signed [PROD_W-1:0] us_s1;
	logic signed [PROD_W-1:0] vc_s1;
	logic [SIDE_W-1:0]        side_s1;
	logic signed [SUM_W-1:0]  sum_u;
	logic signed [SUM_W-1:0]  sum_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	assign sum_u = SUM_W'(uc_s1) - SUM_W'(vs_s1) + RND_HALF;
	assign sum_v = SUM_W'(us_s1) + SUM_W'(vc_s1) + RND_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			uc_s1    <= in_u * cos_v;
			vs_s1    <= in_v * sin_v;
			us_s1    <= in_u * sin_v;
			vc_s1    <= in_v * cos_v;
			side_s1  <= in_side;
			out_u    <= vrp_pkg::COORD_W'(sum_u >>> TRIG_FRAC);
			out_v    <= vrp_pkg::COORD_W'(sum_v >>> TRIG_FRAC);
			out_side <= side_s1;
		end
	end

endmodule

// ===== src/vrp_divider.sv =====
// ----------------------------------------------------------------------------
// vrp_divider
// Two-lane restoring divider, one quotient bit per pipeline stage, shared
// divisor.
// ----------------------------------------------------------------------------
module vrp_divider #(
	parameter int SIDE_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [vrp_pkg::DVD_W-1:0] in_dvd_x,
	input  logic [vrp_pkg::DVD_W-1:0] in_dvd_y,
	input  logic [vrp_pkg::DVS_W-1:0] in_dvs,
	input  logic [SIDE_W-1:0]         in_side,
	output logic                      out_valid,
	output logic [vrp_pkg::DVD_W-1:0] out_quo_x,
	output logic [vrp_pkg::DVD_W-1:0] out_quo_y,
	output logic [SIDE_W-1:0]         out_side
);

	localparam int NW = vrp_pkg::DVD_W;
	localparam int DW = vrp_pkg::DVS_W;

	logic              v_s     [NW+1];
	logic [DW-1:0]     rem_x_s [NW+1];
	logic [DW-1:0]     rem_y_s [NW+1];
	logic [NW-1:0]     nq_x_s  [NW+1];
	logic [NW-1:0]     nq_y_s  [NW+1];
	logic [DW-1:0]     dvs_s   [NW+1];
	logic [SIDE_W-1:0] side_s  [NW+1];

	assign v_s[0]     = in_valid;
	assign rem_x_s[0] = '0;
	assign rem_y_s[0] = '0;
	assign nq_x_s[0]  = in_dvd_x;
	assign nq_y_s[0]  = in_dvd_y;
	assign dvs_s[0]   = in_dvs;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW:0] tx;
		logic [DW:0] ty;
		logic        gex;
		logic        gey;

		assign tx  = {rem_x_s[k], nq_x_s[k][NW-1]};
		assign ty  = {rem_y_s[k], nq_y_s[k][NW-1]};
		assign gex = tx >= {1'b0, dvs_s[k]};
		assign gey = ty >= {1'b0, dvs_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[k+1] <= gex ? DW'(tx - {1'b0, dvs_s[k]}) : tx[DW-1:0];
				rem_y_s[k+1] <= gey ? DW'(ty - {1'b0, dvs_s[k]}) : ty[DW-1:0];
				nq_x_s[k+1]  <= {nq_x_s[k][NW-2:0], gex};
				nq_y_s[k+1]  <= {nq_y_s[k][NW-2:0], gey};
				dvs_s[k+1]   <= dvs_s[k];
				side_s[k+1]  <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign out_quo_x = nq_x_s[NW];
	assign out_quo_y = nq_y_s[NW];
	assign out_side  = side_s[NW];

`ifndef NO_ASSERTIONS
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NW] |-> (rem_x_s[NW] < dvs_s[NW]) && (rem_y_s[NW] < dvs_s[NW]))
		else $error("divider remainder not below divisor");
`endif

endmodule

// ===== src/vertex_rotate_project_core.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// Euler rotation (Y, X, Z) and perspective projection of Q8.8 vertices.
// ----------------------------------------------------------------------------
// Vertices enter on the s_ stream, one beat per vertex; screen points leave
// on the m_ stream, one beat per vertex, in order. Registers are written on
// the cfg_ port (index 0..6: angles x, y, z, focal length, viewer distance,
// screen width, screen height); the user must write them only while no beat
// is in flight, which the block does not enforce. Throughput: one beat per
// cycle while the skid register is empty. The divider (one bit per stage)
// sets the depth; the trig table reads are registered from the angle
// registers, so a vertex may follow a register write in the next cycle.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the output register holds and a skid register
// takes one more beat; the pipeline then freezes and s_tready falls until
// the skid register drains.
// ----------------------------------------------------------------------------
module vertex_rotate_project_core #(
	parameter int ANGLE_BITS = vrp_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_BITS  = vrp_pkg::TRIG_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// vertex_x, vertex_y, vertex_z, color_red, color_green, color_blue
	input  logic [vrp_pkg::TDATA_W-1:0]    s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// screen_x, screen_y, out_red, out_green, out_blue
	output logic [vrp_pkg::MDATA_W-1:0]    m_tdata,
	input  logic                           cfg_we,
	input  logic [vrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW    = vrp_pkg::COORD_W;
	localparam int COL_W = $bits(vrp_pkg::color_t);
	localparam int FW    = vrp_pkg::FIN_W;

	logic [vrp_pkg::ANGLE_W-1:0]     angle_x_q;
	logic [vrp_pkg::ANGLE_W-1:0]     angle_y_q;
	logic [vrp_pkg::ANGLE_W-1:0]     angle_z_q;
	logic [vrp_pkg::FOCAL_W-1:0]     focal_q;
	logic signed [vrp_pkg::DIST_W-1:0] dist_q;
	logic [vrp_pkg::SCREEN_W-1:0]    width_q;
	logic [vrp_pkg::SCREEN_W-1:0]    height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_x_q <= vrp_pkg::ANGLE_RST;
			angle_y_q <= vrp_pkg::ANGLE_RST;
			angle_z_q <= vrp_pkg::ANGLE_RST;
			focal_q   <= vrp_pkg::FOCAL_RST;
			dist_q    <= vrp_pkg::DIST_RST;
			width_q   <= vrp_pkg::WIDTH_RST;
			height_q  <= vrp_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (vrp_pkg::cfg_index_t'(cfg_index))
				vrp_pkg::CFG_ANGLE_X:  angle_x_q <= cfg_data[vrp_pkg::ANGLE_W-1:0];
				vrp_pkg::CFG_ANGLE_Y:  angle_y_q <= cfg_data[vrp_pkg::ANGLE_W-1:0];
				vrp_pkg::CFG_ANGLE_Z:  angle_z_q <= cfg_data[vrp_pkg::ANGLE_W-1:0];
				vrp_pkg::CFG_FOCAL:    focal_q   <= cfg_data[vrp_pkg::FOCAL_W-1:0];
				vrp_pkg::CFG_DISTANCE: dist_q    <= cfg_data[vrp_pkg::DIST_W-1:0];
				vrp_pkg::CFG_WIDTH:    width_q   <= cfg_data[vrp_pkg::SCREEN_W-1:0];
				vrp_pkg::CFG_HEIGHT:   height_q  <= cfg_data[vrp_pkg::SCREEN_W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [TRIG_BITS-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

	vrp_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_x (
		.clk(clk), .angle(ANGLE_BITS'(angle_x_q)), .sin_v(sin_x), .cos_v(cos_x));
	vrp_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_y (
		.clk(clk), .angle(ANGLE_BITS'(angle_y_q)), .sin_v(sin_y), .cos_v(cos_y));
	vrp_trig_rom #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_z (
		.clk(clk), .angle(ANGLE_BITS'(angle_z_q)), .sin_v(sin_z), .cos_v(cos_z));

	logic en;
	logic skid_v_q;
	logic out_v_q;
	vrp_pkg::result_t out_q;
	vrp_pkg::result_t skid_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// input stage
	logic                  v_s1;
	logic signed [CW-1:0]  x_s1, y_s1, z_s1;
	vrp_pkg::color_t       col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= CW'($signed(s_tdata[15:0]));
			y_s1   <= CW'($signed(s_tdata[31:16]));
			z_s1   <= CW'($signed(s_tdata[47:32]));
			col_s1 <= s_tdata[71:48];
		end
	end

	// rotate about y: (u, v) = (z, x)
	logic                 v_ry;
	logic signed [CW-1:0] z_ry, x_ry, y_ry;
	vrp_pkg::color_t      col_ry;

	vrp_rotator #(.TRIG_BITS(TRIG_BITS), .SIDE_W(CW + COL_W)) u_rot_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_u(z_s1), .in_v(x_s1), .in_side({y_s1, col_s1}),
		.sin_v(sin_y), .cos_v(cos_y),
		.out_valid(v_ry), .out_u(z_ry), .out_v(x_ry), .out_side({y_ry, col_ry}));

	// rotate about x: (u, v) = (y, z)
	logic                 v_rx;
	logic signed [CW-1:0] y_rx, z_rx, x_rx;
	vrp_pkg::color_t      col_rx;

	vrp_rotator #(.TRIG_BITS(TRIG_BITS), .SIDE_W(CW + COL_W)) u_rot_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_ry), .in_u(y_ry), .in_v(z_ry), .in_side({x_ry, col_ry}),
		.sin_v(sin_x), .cos_v(cos_x),
		.out_valid(v_rx), .out_u(y_rx), .out_v(z_rx), .out_side({x_rx, col_rx}));

	// rotate about z: (u, v) = (x, y)
	logic                 v_rz;
	logic signed [CW-1:0] x_rz, y_rz, z_rz;
	vrp_pkg::color_t      col_rz;

	vrp_rotator #(.TRIG_BITS(TRIG_BITS), .SIDE_W(CW + COL_W)) u_rot_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_rx), .in_u(x_rx), .in_v(y_rx), .in_side({z_rx, col_rx}),
		.sin_v(sin_z), .cos_v(cos_z),
		.out_valid(v_rz), .out_u(x_rz), .out_v(y_rz), .out_side({z_rz, col_rz}));

	// numerators and denominator
	logic signed [vrp_pkg::DEN_W-1:0] den_sum;
	logic                              v_s8;
	logic signed [vrp_pkg::NUM_W-1:0]  numx_s8, numy_s8;
	logic signed [vrp_pkg::DEN_W-1:0]  den_s8;
	vrp_pkg::color_t                   col_s8;

	assign den_sum = vrp_pkg::DEN_W'(dist_q) + vrp_pkg::DEN_W'(z_rz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_rz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s8 <= $signed({1'b0, focal_q}) * x_rz;
			numy_s8 <= $signed({1'b0, focal_q}) * y_rz;
			den_s8  <= (den_sum == '0) ? vrp_pkg::DEN_W'(1) : den_sum;
			col_s8  <= col_rz;
		end
	end

	// magnitudes and quotient signs
	logic                              v_s9;
	logic [vrp_pkg::MAG_W-1:0]         magx_s9, magy_s9;
	logic [vrp_pkg::DMAG_W-1:0]        dmag_s9;
	logic                              negx_s9, negy_s9;
	vrp_pkg::color_t                   col_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s9 <= vrp_pkg::MAG_W'(numx_s8[vrp_pkg::NUM_W-1] ? -numx_s8 : numx_s8);
			magy_s9 <= vrp_pkg::MAG_W'(numy_s8[vrp_pkg::NUM_W-1] ? -numy_s8 : numy_s8);
			dmag_s9 <= vrp_pkg::DMAG_W'(den_s8[vrp_pkg::DEN_W-1] ? -den_s8 : den_s8);
			negx_s9 <= numx_s8[vrp_pkg::NUM_W-1] ^ den_s8[vrp_pkg::DEN_W-1];
			negy_s9 <= numy_s8[vrp_pkg::NUM_W-1] ^ den_s8[vrp_pkg::DEN_W-1];
			col_s9  <= col_s8;
		end
	end

	// round to nearest: (2n + d) / 2d
	logic                        v_s10;
	logic [vrp_pkg::DVD_W-1:0]   dvdx_s10, dvdy_s10;
	logic [vrp_pkg::DVS_W-1:0]   dvs_s10;
	logic                        negx_s10, negy_s10;
	vrp_pkg::color_t             col_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvdx_s10 <= {magx_s9, 1'b0} + vrp_pkg::DVD_W'(dmag_s9);
			dvdy_s10 <= {magy_s9, 1'b0} + vrp_pkg::DVD_W'(dmag_s9);
			dvs_s10  <= {dmag_s9, 1'b0};
			negx_s10 <= negx_s9;
			negy_s10 <= negy_s9;
			col_s10  <= col_s9;
		end
	end

	logic                      div_v;
	logic [vrp_pkg::DVD_W-1:0] quo_x, quo_y;
	logic                      div_negx, div_negy;
	vrp_pkg::color_t           div_col;

	vrp_divider #(.SIDE_W(COL_W + 2)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s10), .in_dvd_x(dvdx_s10), .in_dvd_y(dvdy_s10), .in_dvs(dvs_s10),
		.in_side({negx_s10, negy_s10, col_s10}),
		.out_valid(div_v), .out_quo_x(quo_x), .out_quo_y(quo_y),
		.out_side({div_negx, div_negy, div_col}));

	// centre offset and saturation
	logic signed [FW-1:0] qx, qy, cx, cy, fin_x, fin_y;
	vrp_pkg::result_t     res;
	logic                 in_fire;

	assign qx    = $signed(FW'(quo_x));
	assign qy    = $signed(FW'(quo_y));
	assign cx    = $signed(FW'({width_q, 7'b0}));
	assign cy    = $signed(FW'({height_q, 7'b0}));
	assign fin_x = div_negx ? cx - qx : cx + qx;
	assign fin_y = div_negy ? cy + qy : cy - qy;

	always_comb begin
		res.color = div_col;
		priority if (fin_x > vrp_pkg::SAT_HI) begin
			res.sx = vrp_pkg::OUT_W'(vrp_pkg::SAT_HI);
		end else if (fin_x < vrp_pkg::SAT_LO) begin
			res.sx = vrp_pkg::OUT_W'(vrp_pkg::SAT_LO);
		end else begin
			res.sx = vrp_pkg::OUT_W'(fin_x);
		end
		priority if (fin_y > vrp_pkg::SAT_HI) begin
			res.sy = vrp_pkg::OUT_W'(vrp_pkg::SAT_HI);
		end else if (fin_y < vrp_pkg::SAT_LO) begin
			res.sy = vrp_pkg::OUT_W'(vrp_pkg::SAT_LO);
		end else begin
			res.sy = vrp_pkg::OUT_W'(fin_y);
		end
	end

	assign in_fire = div_v && en;

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> den_s8 != '0)
		else $error("zero projection denominator");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_v_q && out_v_q && !m_tready && div_v) |=> skid_v_q)
		else $error("beat arriving at stalled output not held in skid register");
`endif

endmodule

// ===== tb/vertex_rotate_project_core_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_core_tb
// Self-checking bench for the vertex rotate and project core: directed and
// random vertices under several register settings, each screen point checked
// against an in-bench fixed-point prediction, with random gaps on both sides.
// ----------------------------------------------------------------------------
module vertex_rotate_project_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [vrp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int QUARTER_STEPS = 1024;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [vrp_pkg::TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [vrp_pkg::MDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [vrp_pkg::ANGLE_W-1:0] ang_x, ang_y, ang_z;
	logic [vrp_pkg::FOCAL_W-1:0] focal;
	logic signed [vrp_pkg::DIST_W-1:0] distance;
	logic [vrp_pkg::SCREEN_W-1:0] scr_width, scr_height;

	vrp_pkg::result_t expected_points[$];
	int errors = 0;
	int points_seen = 0;
	int vertices_sent = 0;
	int cycles = 0;
	bit steady = 1'b0;

	vertex_rotate_project_core DUT (.*);

	always #5 clk = ~clk;

	function automatic longint quarter_sine(longint unsigned r);
		longint unsigned th, th2, term;
		longint sum, res;
		th = (r * HALF_PI_Q30 + QUARTER_STEPS / 2) / QUARTER_STEPS;
		th2 = (th * th) >> 30;
		sum = th;
		term = th;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2) sum -= longint'(term);
			else sum += longint'(term);
		end
		if (sum < 0) sum = 0;
		res = (sum + (64'sd1 << 14)) >>> 15;
		if (res > 32767) res = 32767;
		return res;
	endfunction

	function automatic longint sine(longint unsigned a);
		longint unsigned m, quad, r;
		longint v;
		m = a & 64'hFFF;
		quad = m >> 10;
		r = m & (QUARTER_STEPS - 1);
		v = quad[0] ? quarter_sine(QUARTER_STEPS - r) : quarter_sine(r);
		return quad[1] ? -v : v;
	endfunction

	function automatic longint to_q88(longint p);
		return (p + (64'sd1 << 14)) >>> 15;
	endfunction

	function automatic longint div_nearest(longint num, longint den);
		longint n, d, q;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = (2 * n + d) / (2 * d);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic logic [vrp_pkg::OUT_W-1:0] clamp(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[vrp_pkg::OUT_W-1:0];
	endfunction

	function automatic vrp_pkg::result_t project_vertex(logic [vrp_pkg::TDATA_W-1:0] d);
		longint x, y, z, s, c, t, den;
		vrp_pkg::result_t p;
		x = longint'($signed(d[15:0]));
		y = longint'($signed(d[31:16]));
		z = longint'($signed(d[47:32]));
		s = sine(ang_y); c = sine(ang_y + QUARTER_STEPS);
		t = to_q88(x * c + z * s); z = to_q88(z * c - x * s); x = t;
		s = sine(ang_x); c = sine(ang_x + QUARTER_STEPS);
		t = to_q88(y * c - z * s); z = to_q88(y * s + z * c); y = t;
		s = sine(ang_z); c = sine(ang_z + QUARTER_STEPS);
		t = to_q88(x * c - y * s); y = to_q88(x * s + y * c); x = t;
		den = longint'(distance) + z;
		if (den == 0) den = 1;
		p.sx = clamp(longint'(scr_width) * 128 + div_nearest(longint'(focal) * x, den));
		p.sy = clamp(longint'(scr_height) * 128 - div_nearest(longint'(focal) * y, den));
		p.color = d[71:48];
		return p;
	endfunction

	task automatic write_reg(logic [vrp_pkg::CFG_IDX_W-1:0] idx,
			logic [vrp_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			vrp_pkg::CFG_ANGLE_X: ang_x = val[vrp_pkg::ANGLE_W-1:0];
			vrp_pkg::CFG_ANGLE_Y: ang_y = val[vrp_pkg::ANGLE_W-1:0];
			vrp_pkg::CFG_ANGLE_Z: ang_z = val[vrp_pkg::ANGLE_W-1:0];
			vrp_pkg::CFG_FOCAL: focal = val;
			vrp_pkg::CFG_DISTANCE: distance = val;
			vrp_pkg::CFG_WIDTH: scr_width = val[vrp_pkg::SCREEN_W-1:0];
			vrp_pkg::CFG_HEIGHT: scr_height = val[vrp_pkg::SCREEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [23:0] rgb);
		while (!steady && $urandom_range(99) < 35) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {rgb, z, y, x};
		do @(posedge clk); while (!s_tready);
		expected_points.insert(expected_points.size(), project_vertex(s_tdata));
		vertices_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic settle();
		while (expected_points.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_random(int count);
		repeat (count)
			send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
	endtask

	task automatic test_directed();
		send_vertex(16'h0000, 16'h0000, 16'h0000, 24'h000000);
		send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'hFFFFFF);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 24'h123456);
		send_vertex(16'h0100, 16'hFF00, 16'h0200, 24'hA5A5A5);
		send_vertex(16'h8000, 16'h7FFF, 16'hFC00, 24'h5A5A5A);
		settle();
		// zero denominator: distance cancels z exactly
		write_reg(vrp_pkg::CFG_DISTANCE, 16'h0000);
		send_vertex(16'h0100, 16'h0100, 16'h0000, 24'h010203);
		send_vertex(16'h7FFF, 16'h8000, 16'h0000, 24'hFFFFFF);
		settle();
		write_reg(vrp_pkg::CFG_DISTANCE, 16'hFF00);
		send_vertex(16'h0080, 16'hFF80, 16'h0100, 24'h0F0F0F);
		settle();
		// saturation with largest focal length
		write_reg(vrp_pkg::CFG_FOCAL, 16'hFFFF);
		write_reg(vrp_pkg::CFG_DISTANCE, 16'h0001);
		send_vertex(16'h7FFF, 16'h7FFF, 16'h0000, 24'hC0FFEE);
		send_vertex(16'h8000, 16'h8000, 16'h0000, 24'h00FF00);
		settle();
		write_reg(vrp_pkg::CFG_WIDTH, 16'h1FFF);
		write_reg(vrp_pkg::CFG_HEIGHT, 16'h0000);
		write_reg(CFG_SPARE, 16'hFFFF);
		send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 24'h808080);
		send_vertex(16'h0000, 16'h0000, 16'h0000, 24'h7F7F7F);
		settle();
	endtask

	task automatic test_angle_sweep();
		logic [vrp_pkg::ANGLE_W-1:0] corners[6] = '{12'd0, 12'd1, 12'd1024, 12'd2048,
			12'd3072, 12'd4095};
		write_reg(vrp_pkg::CFG_FOCAL, 16'h0100);
		write_reg(vrp_pkg::CFG_DISTANCE, 16'h0400);
		write_reg(vrp_pkg::CFG_WIDTH, 16'd640);
		write_reg(vrp_pkg::CFG_HEIGHT, 16'd480);
		foreach (corners[i]) begin
			write_reg(vrp_pkg::CFG_ANGLE_X, 16'(corners[i]));
			write_reg(vrp_pkg::CFG_ANGLE_Y, 16'(corners[(i + 2) % 6]));
			write_reg(vrp_pkg::CFG_ANGLE_Z, 16'(corners[(i + 4) % 6]));
			send_random(20);
			settle();
		end
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 10; phase++) begin
			write_reg(vrp_pkg::CFG_ANGLE_X, 16'($urandom));
			write_reg(vrp_pkg::CFG_ANGLE_Y, 16'($urandom));
			write_reg(vrp_pkg::CFG_ANGLE_Z, 16'($urandom));
			write_reg(vrp_pkg::CFG_FOCAL, phase == 0 ? 16'h0000 : 16'($urandom));
			write_reg(vrp_pkg::CFG_DISTANCE, phase == 1 ? 16'h8000 : phase == 2 ? 16'h7FFF :
				16'($urandom));
			write_reg(vrp_pkg::CFG_WIDTH, phase == 3 ? 16'd1 : phase == 4 ? 16'd4096 :
				16'($urandom));
			write_reg(vrp_pkg::CFG_HEIGHT, phase == 3 ? 16'd4096 : phase == 4 ? 16'd1 :
				16'($urandom));
			steady = (phase == 5);
			send_random(140);
			steady = 1'b0;
			settle();
		end
	endtask

	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= 35);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("vertex_rotate_project_core_tb: done, errors");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			vrp_pkg::result_t got, want;
			got = m_tdata;
			points_seen++;
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat %h", $time, m_tdata);
			end else begin
				want = expected_points.pop_front();
				if (got.sx !== want.sx) begin
					errors++;
					$display("%0t: screen_x expected %h got %h", $time, want.sx, got.sx);
				end
				if (got.sy !== want.sy) begin
					errors++;
					$display("%0t: screen_y expected %h got %h", $time, want.sy, got.sy);
				end
				if (got.color !== want.color) begin
					errors++;
					$display("%0t: colour expected %h got %h", $time, want.color,
						got.color);
				end
			end
		end
	end

	initial begin
		ang_x = vrp_pkg::ANGLE_RST;
		ang_y = vrp_pkg::ANGLE_RST;
		ang_z = vrp_pkg::ANGLE_RST;
		focal = vrp_pkg::FOCAL_RST;
		distance = vrp_pkg::DIST_RST;
		scr_width = vrp_pkg::WIDTH_RST;
		scr_height = vrp_pkg::HEIGHT_RST;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_angle_sweep();
		test_random_settings();
		settle();
		$display("Covered %0d vertices and %0d screen points over directed, angle",
			vertices_sent, points_seen);
		$display("sweep and random register settings, with random gaps and stalls.");
		if (errors == 0 && expected_points.size() == 0)
			$display("vertex_rotate_project_core_tb: done, clean");
		else
			$display("vertex_rotate_project_core_tb: done, errors");
		$finish;
	end

endmodule
